@@ design/rplg_pkg.sv @@
// Shared types, codes and the build-time gamma curve table of the palette loader.
`default_nettype none

package rplg_pkg;

  // Input item codes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_END  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int COMP_W    = 6;
  localparam int CURVE_LEN = 2048;

  // Q57 fixed point used by the curve generator
  localparam int          FRAC_BITS = 57;
  localparam logic [63:0] Q_ONE     = 64'd1 << FRAC_BITS;

  typedef enum logic [1:0] {
    OP_RUN,
    OP_PAD,
    OP_READ
  } op_kind_t;

  // One command from the front end to the back end
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic [7:0] count;
    logic       skip;
  } op_t;

  typedef logic [COMP_W-1:0] curve_lut_t [0:CURVE_LEN-1];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FRAC_BITS+63:FRAC_BITS];
  endfunction

  function automatic logic [63:0] qpow(input logic [63:0] base, input logic [10:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = Q_ONE;
    b = base;
    for (int i = 0; i < 11; i++) begin
      if (n[i]) begin
        r = qmul(r, b);
      end
      b = qmul(b, b);
    end
    return r;
  endfunction

  // e^(-1/63) from a 13-term series
  function automatic logic [63:0] exp_step();
    logic [63:0] term;
    logic [63:0] sum;
    term = Q_ONE;
    sum  = Q_ONE;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64(term, 64'(63 * k));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [COMP_W-1:0] gamma_curve(input logic [63:0] q,
                                                    input logic [COMP_W-1:0] c,
                                                    input logic [4:0] g);
    logic [4:0]  a;
    logic [63:0] ea;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] r;
    if (g == 5'd0 || c == '0) begin
      return c;
    end
    a   = g[4] ? 5'(-g) : g;
    ea  = qpow(q, 11'(a) * 11'd63);
    den = Q_ONE - ea;
    if (den == 64'd0) begin
      return c;
    end
    if (!g[4]) begin
      num = Q_ONE - qpow(q, 11'(a) * 11'(c));
    end else begin
      x   = qpow(q, 11'(a) * (11'd63 - 11'(c)));
      num = (x > ea) ? (x - ea) : 64'd0;
    end
    r = udiv64(num * 64'd63, den);
    if (r > 64'd63) begin
      r = 64'd63;
    end
    return r[COMP_W-1:0];
  endfunction

  // Indexed by {gamma, component}
  function automatic curve_lut_t build_curve_lut();
    curve_lut_t  lut;
    logic [63:0] q;
    q = exp_step();
    for (int i = 0; i < CURVE_LEN; i++) begin
      lut[i] = gamma_curve(q, i[5:0], i[10:6]);
    end
    return lut;
  endfunction

  // Widen a 6-bit component to 8 bits by repeating its top bits
  function automatic logic [7:0] widen6(input logic [COMP_W-1:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

`default_nettype wire

@@ design/rplg_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rplg_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ design/rplg_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module rplg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  wire rplg_pkg::op_t  op_i,
  input  wire logic           pop_i,
  output rplg_pkg::op_t       op_o,
  output logic                full_o,
  output logic                empty_o
);

  rplg_pkg::op_t                 mem_r [rplg_pkg::QUEUE_DEPTH];
  logic [rplg_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [rplg_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [rplg_pkg::QPTR_W:0]     count_r;

  assign full_o  = (count_r == (rplg_pkg::QPTR_W + 1)'(rplg_pkg::QUEUE_DEPTH));
  assign empty_o = (count_r == '0);
  assign op_o    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= op_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count lost a transfer");
`endif

endmodule

`default_nettype wire

@@ design/rplg_front.sv @@
// Front end: accepts items, tracks escapes and fill level, issues commands.
`default_nettype none

module rplg_front #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start_i,
  input  wire logic           q_full_i,
  input  wire logic [1:0]     mode_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           skip_i,
  input  wire logic [7:0]     index_i,
  output logic                push_o,
  output rplg_pkg::op_t       op_o
);

  localparam int PAYLOAD = 3 * PALETTE_ENTRIES;
  localparam int CW      = $clog2(PAYLOAD + 1);
  localparam int XW      = (CW > 8) ? CW : 8;

  typedef enum logic [1:0] {
    F_LIT,
    F_VAL,
    F_CNT
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [7:0]     run_value_r, run_value_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;

  logic           accept;
  logic           overflow;
  logic [XW-1:0]  room;
  logic [XW-1:0]  run_n;

  assign accept   = start_i && !q_full_i;
  assign overflow = (fill_r == CW'(PAYLOAD));
  assign room     = XW'(PAYLOAD) - XW'(fill_r);
  // Clip runs at the end of the payload
  assign run_n    = (XW'(byte_i) > room) ? room : XW'(byte_i);

  always_comb begin
    phase_nxt     = phase_r;
    run_value_nxt = run_value_r;
    fill_nxt      = fill_r;
    push_o        = 1'b0;
    op_o.kind     = rplg_pkg::OP_RUN;
    op_o.value    = byte_i;
    op_o.count    = 8'd1;
    op_o.skip     = skip_i;
    if (accept) begin
      case (mode_i)
        rplg_pkg::MODE_BYTE: begin
          if (!overflow) begin
            case (phase_r)
              F_VAL: begin
                run_value_nxt = byte_i;
                phase_nxt     = F_CNT;
              end
              F_CNT: begin
                phase_nxt  = F_LIT;
                op_o.value = run_value_r;
                op_o.count = run_n[7:0];
                push_o     = (run_n != '0);
                fill_nxt   = CW'(XW'(fill_r) + run_n);
              end
              default: begin
                if (byte_i == rplg_pkg::ESCAPE_BYTE) begin
                  phase_nxt = F_VAL;
                end else begin
                  push_o   = 1'b1;
                  fill_nxt = fill_r + 1'b1;
                end
              end
            endcase
          end
        end
        rplg_pkg::MODE_END: begin
          op_o.kind = rplg_pkg::OP_PAD;
          push_o    = 1'b1;
          fill_nxt  = '0;
          phase_nxt = F_LIT;
        end
        rplg_pkg::MODE_READ: begin
          op_o.kind  = rplg_pkg::OP_READ;
          op_o.value = index_i;
          push_o     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= F_LIT;
      run_value_r <= '0;
      fill_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      run_value_r <= run_value_nxt;
      fill_r      <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/rplg_back.sv @@
// Back end: expands runs into triples, writes the palette store, serves reads.
`default_nettype none

module rplg_back #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [4:0]     gamma_i,
  input  wire rplg_pkg::op_t  op_i,
  input  wire logic           op_valid_i,
  output logic                pop_o,
  output logic                out_strobe_o,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int EW = 3 * rplg_pkg::COMP_W;
  localparam rplg_pkg::curve_lut_t CURVE_LUT = rplg_pkg::build_curve_lut();

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN,
    B_PAD,
    B_FETCH,
    B_LOOK_R,
    B_LOOK_G,
    B_LOOK_B,
    B_SEND
  } state_t;

  state_t                       state_r;
  logic [7:0]                   val_r;
  logic [7:0]                   left_r;
  logic                         skip_r;
  logic [1:0]                   slot_r;
  logic [AW-1:0]                entry_r;
  logic                         full_r;
  logic [7:0]                   pend_red_r;
  logic [7:0]                   pend_green_r;
  logic [PALETTE_ENTRIES-1:0]   valid_r;
  logic                         rd_ok_r;
  logic [EW-1:0]                pix_r;
  logic [rplg_pkg::COMP_W-1:0]  rom_q_r;
  logic [rplg_pkg::COMP_W-1:0]  red_r;
  logic [rplg_pkg::COMP_W-1:0]  green_r;

  logic                         emit;
  logic [7:0]                   emit_v;
  logic                         ram_we;
  logic [EW-1:0]                ram_wdata;
  logic [EW-1:0]                ram_rdata;
  logic [AW-1:0]                rd_addr;
  logic                         in_range;
  logic                         black;

  assign pop_o    = (state_r == B_IDLE) && op_valid_i;
  assign rd_addr  = op_i.value[AW-1:0];
  assign in_range = ({1'b0, op_i.value} < 9'(PALETTE_ENTRIES));

  always_comb begin
    emit   = 1'b0;
    emit_v = val_r;
    case (state_r)
      B_RUN: begin
        emit = 1'b1;
      end
      B_PAD: begin
        emit   = !full_r;
        emit_v = 8'd0;
      end
      default: begin
      end
    endcase
  end

  assign black     = (pend_red_r == 8'd0) && (pend_green_r == 8'd0) && (emit_v == 8'd0);
  assign ram_we    = emit && (slot_r == 2'd2) && !(skip_r && black);
  assign ram_wdata = {pend_red_r[rplg_pkg::COMP_W-1:0], pend_green_r[rplg_pkg::COMP_W-1:0],
                      emit_v[rplg_pkg::COMP_W-1:0]};

  rplg_ram #(
    .WIDTH (EW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_r),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      slot_r       <= '0;
      entry_r      <= '0;
      full_r       <= 1'b0;
      valid_r      <= '0;
      out_strobe_o <= 1'b0;
    end else begin
      out_strobe_o <= 1'b0;
      if (emit) begin
        case (slot_r)
          2'd0: begin
            pend_red_r <= emit_v;
            slot_r     <= 2'd1;
          end
          2'd1: begin
            pend_green_r <= emit_v;
            slot_r       <= 2'd2;
          end
          default: begin
            if (ram_we) begin
              valid_r[entry_r] <= 1'b1;
            end
            slot_r <= 2'd0;
            if (entry_r == AW'(PALETTE_ENTRIES - 1)) begin
              full_r <= 1'b1;
            end else begin
              entry_r <= entry_r + 1'b1;
            end
          end
        endcase
      end
      case (state_r)
        B_IDLE: begin
          if (pop_o) begin
            val_r  <= op_i.value;
            left_r <= op_i.count;
            skip_r <= op_i.skip;
            case (op_i.kind)
              rplg_pkg::OP_RUN:  state_r <= B_RUN;
              rplg_pkg::OP_PAD:  state_r <= B_PAD;
              rplg_pkg::OP_READ: begin
                rd_ok_r <= in_range && valid_r[rd_addr];
                state_r <= B_FETCH;
              end
              default: state_r <= B_IDLE;
            endcase
          end
        end
        B_RUN: begin
          left_r <= left_r - 1'b1;
          if (left_r == 8'd1) begin
            state_r <= B_IDLE;
          end
        end
        B_PAD: begin
          if (full_r) begin
            slot_r  <= '0;
            entry_r <= '0;
            full_r  <= 1'b0;
            state_r <= B_IDLE;
          end
        end
        B_FETCH: begin
          pix_r   <= rd_ok_r ? ram_rdata : '0;
          state_r <= B_LOOK_R;
        end
        B_LOOK_R: begin
          rom_q_r <= CURVE_LUT[{gamma_i, pix_r[17:12]}];
          state_r <= B_LOOK_G;
        end
        B_LOOK_G: begin
          red_r   <= rom_q_r;
          rom_q_r <= CURVE_LUT[{gamma_i, pix_r[11:6]}];
          state_r <= B_LOOK_B;
        end
        B_LOOK_B: begin
          green_r <= rom_q_r;
          rom_q_r <= CURVE_LUT[{gamma_i, pix_r[5:0]}];
          state_r <= B_SEND;
        end
        B_SEND: begin
          out_strobe_o <= 1'b1;
          out_red_o    <= rplg_pkg::widen6(red_r);
          out_green_o  <= rplg_pkg::widen6(green_r);
          out_blue_o   <= rplg_pkg::widen6(rom_q_r);
          state_r      <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_o |=> !out_strobe_o)
    else $error("result strobe held for more than one cycle");

  a_write_when_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == B_RUN || state_r == B_PAD))
    else $error("palette store written outside run or pad");

  a_full_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (slot_r == 2'd0))
    else $error("payload full with a partial triple pending");
`endif

endmodule

`default_nettype wire

@@ design/rle_palette_loader_with_gamma.sv @@
// Top level of the escape-byte RLE palette loader with gamma-corrected reads.
`default_nettype none

// Palette loader. Items are transferred on start while busy is low; busy
// rises only when the four-deep command queue between the front end and
// the back end is full, so the front end takes one item per cycle until
// then. The back end sets the pace and takes a new command only when idle:
// a run is expanded into its bytes one by one, end of payload pads zero
// bytes up to the full payload (768 by default), and a palette read goes
// through a store read, then three lookups of the gamma table, one
// component each. Each result appears on out_red, out_green and out_blue
// for one cycle with out_strobe high; the receiver cannot stall, so take
// it then. The store powers up cleared through a valid bit per entry, with
// no clearing pass. Write gamma only while idle; cfg_ready is always high.
module rle_palette_loader_with_gamma #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_mode,
  input  wire logic [7:0]        in_payload_byte,
  input  wire logic              in_skip_black,
  input  wire logic [7:0]        in_entry_index,
  // Result channel
  output logic                   out_strobe,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  // Configuration channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic signed [4:0] cfg_gamma
);

  logic [4:0]     gamma_bits_r;
  rplg_pkg::op_t  push_op;
  rplg_pkg::op_t  head_op;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Hold the curve strength; a transfer on the config channel replaces it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_bits_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      gamma_bits_r <= cfg_gamma;
    end
  end

  // Stall the input side only when the queue has no room
  assign busy = q_full;

  rplg_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .q_full_i (q_full),
    .mode_i   (in_mode),
    .byte_i   (in_payload_byte),
    .skip_i   (in_skip_black),
    .index_i  (in_entry_index),
    .push_o   (push),
    .op_o     (push_op)
  );

  rplg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rplg_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .gamma_i      (gamma_bits_r),
    .op_i         (head_op),
    .op_valid_i   (!q_empty),
    .pop_o        (pop),
    .out_strobe_o (out_strobe),
    .out_red_o    (out_red),
    .out_green_o  (out_green),
    .out_blue_o   (out_blue)
  );

endmodule

`default_nettype wire

@@ tb/rplg_palette_checker.sv @@
// Checker for the palette loader: mirrors its decoding, predicts every palette read, compares.
module rplg_palette_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [1:0]        in_mode,
  input  wire logic [7:0]        in_payload_byte,
  input  wire logic              in_skip_black,
  input  wire logic [7:0]        in_entry_index,
  input  wire logic              out_strobe,
  input  wire logic [7:0]        out_red,
  input  wire logic [7:0]        out_green,
  input  wire logic [7:0]        out_blue,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic signed [4:0] cfg_gamma,
  output int                     fail_count,
  output int                     pending
);

  localparam int          ENTRIES     = 256;
  localparam int          PAYLOAD_LEN = 3 * ENTRIES;
  localparam logic [63:0] FX_ONE      = 64'd1 << 57;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shade_t;

  typedef enum logic [1:0] {
    EXPECT_PLAIN,
    EXPECT_VALUE,
    EXPECT_COUNT
  } rle_phase_t;

  logic [17:0] palette_q [0:ENTRIES-1];
  rle_phase_t  rle_phase;
  logic [7:0]  run_byte;
  int          fill;
  logic [7:0]  held_red;
  logic [7:0]  held_green;
  logic [4:0]  gamma_bits;
  logic [5:0]  curve_lut [0:31][0:63];
  shade_t      expected_shades [$];

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return wide[120:57];
  endfunction

  // unit_decay raised to the power n
  function automatic logic [63:0] fx_decay(input logic [63:0] unit_decay, input int unsigned n);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = FX_ONE;
    sq  = unit_decay;
    while (n != 0) begin
      if (n[0]) begin
        acc = fx_mul(acc, sq);
      end
      sq = fx_mul(sq, sq);
      n  = n >> 1;
    end
    return acc;
  endfunction

  function automatic logic [5:0] shade_curve(input logic [63:0] unit_decay, input int c,
                                             input int g);
    int          a;
    logic [63:0] floor_v;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] lift;
    if (g == 0 || c == 0) begin
      return 6'(c);
    end
    a       = (g < 0) ? -g : g;
    floor_v = fx_decay(unit_decay, 63 * a);
    den     = FX_ONE - floor_v;
    if (den == 64'd0) begin
      return 6'(c);
    end
    if (g > 0) begin
      num = FX_ONE - fx_decay(unit_decay, a * c);
    end else begin
      lift = fx_decay(unit_decay, a * (63 - c));
      num  = (lift > floor_v) ? lift - floor_v : 64'd0;
    end
    num = (num * 64'd63) / den;
    return (num > 64'd63) ? 6'd63 : num[5:0];
  endfunction

  initial begin : build_curves
    logic [63:0] term;
    logic [63:0] unit_decay;
    term       = FX_ONE;
    unit_decay = FX_ONE;
    for (int k = 1; k <= 12; k++) begin
      term       = term / 64'(63 * k);
      unit_decay = (k % 2 == 1) ? unit_decay - term : unit_decay + term;
    end
    for (int g = -16; g < 16; g++) begin
      for (int c = 0; c < 64; c++) begin
        curve_lut[5'(g)][c] = shade_curve(unit_decay, c, g);
      end
    end
  end

  function automatic logic [7:0] corrected(input logic [5:0] comp);
    logic [5:0] v;
    v = curve_lut[gamma_bits][comp];
    return {v, v[5:4]};
  endfunction

  task automatic push_byte(input logic [7:0] v, input logic skip);
    if (fill >= PAYLOAD_LEN) begin
      return;
    end
    case (fill % 3)
      0: held_red = v;
      1: held_green = v;
      default: begin
        if (!(skip && held_red == 8'd0 && held_green == 8'd0 && v == 8'd0)) begin
          palette_q[fill / 3] = {held_red[5:0], held_green[5:0], v[5:0]};
        end
      end
    endcase
    fill++;
  endtask

  task automatic absorb_item();
    shade_t s;
    case (in_mode)
      rplg_pkg::MODE_BYTE: begin
        if (fill < PAYLOAD_LEN) begin
          case (rle_phase)
            EXPECT_VALUE: begin
              run_byte  = in_payload_byte;
              rle_phase = EXPECT_COUNT;
            end
            EXPECT_COUNT: begin
              for (int k = 0; k < in_payload_byte; k++) begin
                push_byte(run_byte, in_skip_black);
              end
              rle_phase = EXPECT_PLAIN;
            end
            default: begin
              if (in_payload_byte == rplg_pkg::ESCAPE_BYTE) begin
                rle_phase = EXPECT_VALUE;
              end else begin
                push_byte(in_payload_byte, in_skip_black);
              end
            end
          endcase
        end
      end
      rplg_pkg::MODE_END: begin
        while (fill < PAYLOAD_LEN) begin
          push_byte(8'd0, in_skip_black);
        end
        rle_phase  = EXPECT_PLAIN;
        fill       = 0;
        held_red   = 8'd0;
        held_green = 8'd0;
      end
      rplg_pkg::MODE_READ: begin
        s.red   = corrected(palette_q[in_entry_index][17:12]);
        s.green = corrected(palette_q[in_entry_index][11:6]);
        s.blue  = corrected(palette_q[in_entry_index][5:0]);
        expected_shades.push_back(s);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    shade_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        palette_q[i] = '0;
      end
      rle_phase  = EXPECT_PLAIN;
      run_byte   = 8'd0;
      fill       = 0;
      held_red   = 8'd0;
      held_green = 8'd0;
      gamma_bits = 5'd0;
      fail_count = 0;
      expected_shades.delete();
    end else begin
      if (out_strobe) begin
        if (expected_shades.size() == 0) begin
          $error("unrequested result: red %0d green %0d blue %0d", out_red, out_green,
                 out_blue);
          fail_count++;
        end else begin
          want = expected_shades.pop_front();
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
        end
      end
      if (cfg_valid && cfg_ready) begin
        gamma_bits = cfg_gamma;
      end
      if (start && !busy) begin
        absorb_item();
      end
    end
    pending = expected_shades.size();
  end

endmodule

@@ tb/tb_rle_palette_loader_with_gamma.sv @@
// Testbench top for the palette loader: drives payloads, reads and gamma writes, gives the verdict.
module tb_rle_palette_loader_with_gamma;

  // Mode 3 has no meaning in the block; it must be swallowed silently
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam int         PAYLOAD_LEN  = 768;
  localparam int         RANDOM_ITEMS = 1850;
  localparam int         PHASE_ITEMS  = 230;
  // Worst case is every item a 255-byte run plus a full pad per load, taken
  // several times over; the real run is a small fraction of this
  localparam int         CYCLE_LIMIT  = 2_000_000;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic [1:0]        in_mode         = rplg_pkg::MODE_BYTE;
  logic [7:0]        in_payload_byte = 8'd0;
  logic              in_skip_black   = 1'b0;
  logic [7:0]        in_entry_index  = 8'd0;
  logic              cfg_valid       = 1'b0;
  logic signed [4:0] cfg_gamma       = 5'sd0;
  logic              busy;
  logic              out_strobe;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic              cfg_ready;
  int                fail_count;
  int                pending;

  // Bytes decoded so far in the current load, as the stimulus sees it; used
  // only to tell which bytes the block will ignore after overflow
  int                load_fill   = 0;
  int                items_done  = 0;
  bit                steady      = 1'b0;
  int                cycles      = 0;

  rle_palette_loader_with_gamma uut (.*);

  rplg_palette_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung block or a lost result ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_rle_palette_loader_with_gamma: errors");
      $finish;
    end
  end

  // Present one item and hold it until transferred; then, unless in a steady
  // stretch, sometimes drop start for a random gap. With no gap, start stays high and
  // the next call simply overwrites the fields in the same step.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] payload,
                           input logic skip, input logic [7:0] index);
    start           <= 1'b1;
    in_mode         <= mode;
    in_payload_byte <= payload;
    in_skip_black   <= skip;
    in_entry_index  <= index;
    do @(posedge clk); while (busy);
    if (!steady && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 4)) @(posedge clk);
    end
  endtask

  task automatic feed_literal(input logic [7:0] b, input logic skip);
    if (load_fill < PAYLOAD_LEN) begin
      items_done++;
      load_fill++;
    end
    send_item(rplg_pkg::MODE_BYTE, b, skip, 8'($urandom));
  endtask

  // Escape, value, count: one run
  task automatic feed_run(input logic [7:0] value, input logic [7:0] count, input logic skip);
    if (load_fill < PAYLOAD_LEN) begin
      items_done += 3;
    end
    send_item(rplg_pkg::MODE_BYTE, rplg_pkg::ESCAPE_BYTE, skip, 8'($urandom));
    send_item(rplg_pkg::MODE_BYTE, value, skip, 8'($urandom));
    send_item(rplg_pkg::MODE_BYTE, count, skip, 8'($urandom));
    load_fill = (load_fill + count > PAYLOAD_LEN) ? PAYLOAD_LEN : load_fill + count;
  endtask

  task automatic feed_escape_part(input logic [7:0] b, input logic skip);
    if (load_fill < PAYLOAD_LEN) begin
      items_done++;
    end
    send_item(rplg_pkg::MODE_BYTE, b, skip, 8'($urandom));
  endtask

  task automatic read_entry(input logic [7:0] index);
    items_done++;
    send_item(rplg_pkg::MODE_READ, 8'($urandom), 1'($urandom), index);
  endtask

  task automatic end_load(input logic skip);
    items_done++;
    send_item(rplg_pkg::MODE_END, 8'($urandom), skip, 8'($urandom));
    load_fill = 0;
  endtask

  task automatic spare_item();
    send_item(MODE_SPARE, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Finish with a read: the back end works in order, so once its result is
  // in, every earlier run and pad is done and the block is idle
  task automatic settle();
    read_entry(8'($urandom));
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_gamma(input logic signed [4:0] g);
    settle();
    cfg_valid <= 1'b1;
    cfg_gamma <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Literals: plenty of zeros for the black-skip path, plenty of values with
  // the top two bits set to exercise the 6-bit mask; never the escape code
  function automatic logic [7:0] pick_literal();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return 8'd0;
    end else if (r < 60) begin
      return 8'($urandom_range(0, 63));
    end
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      return 8'd0;
    end else if (r < 35) begin
      return rplg_pkg::ESCAPE_BYTE;
    end
    return 8'($urandom);
  endfunction

  // Mostly short runs; large ones in big loads push the payload past 768
  function automatic logic [7:0] pick_count(input bit big);
    int r;
    r = $urandom_range(0, 99);
    if (big) begin
      return (r < 50) ? 8'($urandom_range(100, 255)) : 8'($urandom);
    end else if (r < 10) begin
      return 8'd0;
    end else if (r < 90) begin
      return 8'($urandom_range(1, 9));
    end
    return 8'($urandom_range(10, 60));
  endfunction

  // Half the reads aim at the low entries that short loads actually write
  function automatic logic [7:0] pick_index();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
  endfunction

  // One load: a well-formed payload with reads mixed in, a little noise (the
  // spare mode, skip_black flipping mid-load), sometimes an escape cut short
  // by the end, then a handful of reads of the result
  task automatic gen_load(input bit big);
    logic skip;
    int   len;
    int   r;
    skip = 1'($urandom);
    len  = $urandom_range(6, 45);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        read_entry(pick_index());
      end else if (r < 56) begin
        feed_literal(pick_literal(), skip);
      end else if (r < 86) begin
        feed_run(pick_value(), pick_count(big), skip);
      end else if (r < 90) begin
        spare_item();
      end else if (r < 94) begin
        feed_literal(pick_literal(), ~skip);
      end else begin
        feed_literal(8'd0, skip);
      end
    end
    case ($urandom_range(0, 7))
      0: feed_escape_part(rplg_pkg::ESCAPE_BYTE, skip);
      1: begin
        feed_escape_part(rplg_pkg::ESCAPE_BYTE, skip);
        feed_escape_part(pick_value(), skip);
      end
      default: ;
    endcase
    end_load(skip);
    repeat ($urandom_range(2, 10)) read_entry(pick_index());
  endtask

  function automatic logic signed [4:0] phase_gamma(input int phase);
    case (phase)
      0:       return 5'sd15;
      1:       return -5'sd16;
      2:       return 5'sd0;
      3:       return 5'sd1;
      4:       return -5'sd1;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int phase_start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, gamma still at its reset value of zero.
    // A cleared store reads as black.
    read_entry(8'd0);
    // Entry 0 from literals, top bits masked off
    feed_literal(8'h3F, 1'b0);
    feed_literal(8'h40, 1'b0);
    feed_literal(8'hFE, 1'b0);
    // A run whose value is the escape code itself, completed by a literal
    feed_run(rplg_pkg::ESCAPE_BYTE, 8'd2, 1'b0);
    feed_literal(8'h80, 1'b0);
    // A run of count zero adds nothing
    feed_run(8'h12, 8'd0, 1'b0);
    // Read in the middle of a load, then the unused mode
    read_entry(8'd1);
    spare_item();
    // An escape left hanging when the payload ends is dropped; the pad
    // zeros the rest
    feed_escape_part(rplg_pkg::ESCAPE_BYTE, 1'b0);
    end_load(1'b0);
    read_entry(8'd1);
    // Second load with skip_black: an all-zero triple leaves entry 0 alone,
    // then three long runs overflow the payload and the trailing literal is
    // ignored
    feed_run(8'h00, 8'd3, 1'b1);
    feed_run(8'h2A, 8'd255, 1'b1);
    feed_run(8'hC0, 8'd255, 1'b1);
    feed_run(8'h15, 8'd255, 1'b1);
    feed_literal(8'h11, 1'b1);
    end_load(1'b1);
    read_entry(8'd0);
    read_entry(8'd255);

    // Random part, in phases of one gamma setting each; the sender drains
    // completely before every register write. One phase runs with no gaps.
    items_done = 0;
    phase      = 0;
    while (items_done < RANDOM_ITEMS) begin
      write_gamma(phase_gamma(phase));
      steady      = (phase == 2);
      phase_start = items_done;
      while (items_done - phase_start < PHASE_ITEMS && items_done < RANDOM_ITEMS) begin
        gen_load($urandom_range(0, 3) == 0);
      end
      phase++;
    end
    steady = 1'b0;
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("tb_rle_palette_loader_with_gamma: clean");
    end else begin
      $display("tb_rle_palette_loader_with_gamma: errors");
    end
    $finish;
  end

endmodule

@@ rle_palette_loader_with_gamma.f @@
design/rplg_pkg.sv
design/rplg_ram.sv
design/rplg_queue.sv
design/rplg_front.sv
design/rplg_back.sv
design/rle_palette_loader_with_gamma.sv
tb/rplg_palette_checker.sv
tb/tb_rle_palette_loader_with_gamma.sv
